// ===== design/kbpx_pkg.sv =====
// kbpx_pkg: shared types, register codes and helper functions of the keyed
// bit-permutation cipher. Used by every module of the design folder; no dependencies.
package kbpx_pkg;

   localparam int WordBits = 32;
   localparam int IdxBits  = 5;
   localparam int KeyBits  = 160;
   localparam int AddrBits = 5;
   localparam int CsrBits  = 64;

   // register select codes (paddr[4:3])
   localparam logic [1:0] RegKeyLow  = 2'd0;
   localparam logic [1:0] RegKeyMid  = 2'd1;
   localparam logic [1:0] RegKeyHigh = 2'd2;

   // key field masks, by remaining free count
   localparam logic [IdxBits-1:0] FieldMask5 = 5'h1F;
   localparam logic [IdxBits-1:0] FieldMask4 = 5'h0F;
   localparam logic [IdxBits-1:0] FieldMask3 = 5'h07;
   localparam logic [IdxBits-1:0] FieldMask2 = 5'h03;
   localparam logic [IdxBits-1:0] FieldMask1 = 5'h01;
   localparam logic [7:0]         ByteMask   = 8'hFF;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] mid;
      logic [31:0] high;
   } key_type;

   // permutation rebuild request from the register file
   typedef struct packed {
      logic    start;
      key_type key;
   } build_req_type;

   typedef logic [WordBits-1:0][IdxBits-1:0] order_tab_type;

   // mask of the key field for permutation entry idx
   function automatic logic [IdxBits-1:0] field_mask(input logic [IdxBits-1:0] idx);
      logic [IdxBits-1:0] m;
      priority if (idx < 5'd16) m = FieldMask5;
      else if (idx < 5'd24)     m = FieldMask4;
      else if (idx < 5'd28)     m = FieldMask3;
      else if (idx < 5'd30)     m = FieldMask2;
      else if (idx == 5'd30)    m = FieldMask1;
      else                      m = '0;
      return m;
   endfunction

   // stream bits consumed by entry idx
   function automatic logic [2:0] field_width(input logic [IdxBits-1:0] idx);
      logic [2:0] w;
      priority if (idx < 5'd16) w = 3'd5;
      else if (idx < 5'd24)     w = 3'd4;
      else if (idx < 5'd28)     w = 3'd3;
      else if (idx < 5'd30)     w = 3'd2;
      else                      w = 3'd0;
      return w;
   endfunction

   // position-keyed XOR pad; byte 0 lands in the top byte
   function automatic logic [WordBits-1:0] xor_pad(input logic [31:0] pos,
                                                    input logic [31:0] key_high);
      logic [7:0]          hi;
      logic [7:0]          off;
      logic [7:0]          m;
      logic [WordBits-1:0] pad;
      hi  = pos[15:8] ^ pos[23:16] ^ pos[31:24];
      pad = '0;
      for (int c = 0; c < 4; c++) begin
         off = (pos[7:0] + 8'(c)) ^ hi;
         m   = (key_high[8*c +: 8] + off) & ByteMask;
         pad[WordBits-1-8*c -: 8] = m;
      end
      return pad;
   endfunction

endpackage

// ===== design/kbpx_csr.sv =====
// kbpx_csr: APB-style key register file; raises a rebuild request on each key write.
// Depends on kbpx_pkg.
module kbpx_csr import kbpx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [AddrBits-1:0] paddr,
   input  logic [CsrBits-1:0]  pwdata,
   output logic [CsrBits-1:0]  prdata,
   output logic                pready,
   output build_req_type       build_req
);

   key_type    key_ff, key_in;
   logic       start_ff, start_in;
   logic       write_en;
   logic [1:0] reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign reg_sel  = paddr[4:3];

   // update the addressed key word; flag a rebuild for known registers
   always_comb begin
      key_in   = key_ff;
      start_in = 1'b0;
      if (write_en) begin
         unique case (reg_sel)
            RegKeyLow: begin
               key_in.low = pwdata;
               start_in   = 1'b1;
            end
            RegKeyMid: begin
               key_in.mid = pwdata;
               start_in   = 1'b1;
            end
            RegKeyHigh: begin
               key_in.high = pwdata[31:0];
               start_in    = 1'b1;
            end
            default: begin
               start_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         start_ff <= start_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         RegKeyLow:  prdata = key_ff.low;
         RegKeyMid:  prdata = key_ff.mid;
         RegKeyHigh: prdata = {32'd0, key_ff.high};
         default:    prdata = '0;
      endcase
   end

   assign build_req.start = start_ff;
   assign build_req.key   = key_ff;

endmodule

// ===== design/kbpx_order_gen.sv =====
// kbpx_order_gen: rebuilds the bit permutation and its inverse from the key,
// one entry per cycle. Depends on kbpx_pkg.
module kbpx_order_gen import kbpx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  build_req_type build_req,
   output order_tab_type order_tab,
   output order_tab_type inv_tab,
   output logic          busy
);

   order_tab_type       order_ff, order_in;
   order_tab_type       inv_ff, inv_in;
   logic [KeyBits-1:0]  stream_ff, stream_in;
   logic [WordBits-1:0] taken_ff, taken_in;
   logic [IdxBits-1:0]  idx_ff, idx_in;
   logic                busy_ff, busy_in;

   logic [IdxBits-1:0]  mx;
   logic [IdxBits-1:0]  raw_n;
   logic [IdxBits-1:0]  nth;
   logic [IdxBits-1:0]  pick;
   logic [5:0]          zeros;

   // field value for this entry, folded into the free range
   always_comb begin
      mx    = 5'd31 - idx_ff;
      raw_n = stream_ff[IdxBits-1:0] & field_mask(idx_ff);
      nth   = (raw_n > mx) ? (raw_n - mx) : raw_n;
   end

   // select the nth free bit index
   always_comb begin
      pick  = '0;
      zeros = '0;
      for (int j = 0; j < WordBits; j++) begin
         zeros = 6'($countones(~taken_ff & ((32'd1 << j) - 32'd1)));
         if (!taken_ff[j] && (zeros == {1'b0, nth})) begin
            pick = 5'(j);
         end
      end
   end

   // sequencer: load on request, then one entry a cycle
   always_comb begin
      order_in  = order_ff;
      inv_in    = inv_ff;
      stream_in = stream_ff;
      taken_in  = taken_ff;
      idx_in    = idx_ff;
      busy_in   = busy_ff;
      if (build_req.start) begin
         stream_in = {build_req.key.high, build_req.key.mid, build_req.key.low};
         taken_in  = '0;
         idx_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         order_in[idx_ff] = pick;
         inv_in[pick]     = idx_ff;
         taken_in         = taken_ff | (32'd1 << pick);
         stream_in        = stream_ff >> field_width(idx_ff);
         idx_in           = idx_ff + 5'd1;
         if (idx_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WordBits; k++) begin
            order_ff[k] <= 5'(k);
            inv_ff[k]   <= 5'(k);
         end
         taken_ff <= '0;
         idx_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         order_ff <= order_in;
         inv_ff   <= inv_in;
         taken_ff <= taken_in;
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
      end
   end

   // key stream copy is payload
   always_ff @(posedge clock) begin
      stream_ff <= stream_in;
   end

   assign order_tab = order_ff;
   assign inv_tab   = inv_ff;
   assign busy      = build_req.start | busy_ff;

endmodule

// ===== design/kbpx_word_pipe.sv =====
// kbpx_word_pipe: input register, permute/XOR logic and result register for
// one word per cycle while hold is low and no result stalls. Depends on kbpx_pkg.
module kbpx_word_pipe import kbpx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                hold,
   input  order_tab_type       order_tab,
   input  order_tab_type       inv_tab,
   input  logic [31:0]         key_high,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [31:0]         req_position,
   input  logic [WordBits-1:0] req_data_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WordBits-1:0] rsp_result_word
);

   logic                s1_valid_ff, s1_valid_in;
   opcode_type          s1_op_ff;
   logic [31:0]         s1_pos_ff;
   logic [WordBits-1:0] s1_word_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic [WordBits-1:0] s2_word_ff;

   logic                s2_free;
   logic                s1_free;
   logic                req_take;
   logic [WordBits-1:0] pad;
   logic [WordBits-1:0] padded;
   logic [WordBits-1:0] result;

   // stage handshakes
   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free && !hold;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_free ? req_take : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   end

   // permute then pad on encrypt, pad then unpermute on decrypt
   always_comb begin
      pad    = xor_pad(s1_pos_ff, key_high);
      padded = s1_word_ff ^ pad;
      result = '0;
      unique case (s1_op_ff)
         OP_ENCRYPT: begin
            for (int j = 0; j < WordBits; j++) begin
               result[j] = s1_word_ff[inv_tab[j]];
            end
            result = result ^ pad;
         end
         OP_DECRYPT: begin
            for (int i = 0; i < WordBits; i++) begin
               result[i] = padded[order_tab[i]];
            end
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= opcode_type'(req_opcode);
         s1_pos_ff  <= req_position;
         s1_word_ff <= req_data_word;
      end
      if (s2_free && s1_valid_ff) begin
         s2_word_ff <= result;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_result_word = s2_word_ff;

endmodule

// ===== design/keyed_bit_permute_xor_cipher_core.sv =====
// keyed_bit_permute_xor_cipher_core: top level of the keyed bit-permutation cipher.
// Depends on kbpx_pkg, kbpx_csr, kbpx_order_gen and kbpx_word_pipe.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   request | req_opcode, req_position, req_data_word | req_valid / req_ready
//   result  | rsp_result_word                         | rsp_valid / rsp_ready
//   config  | paddr, pwdata, prdata (keys at 0, 8, 16)| psel, penable, pwrite
//
// One request per cycle while req_ready is high; a taken request passes the input
// register and then the result register. Reset loads the identity permutation and
// clears the keys, so requests flow at once. A key write starts a permutation rebuild
// (one entry a cycle in kbpx_order_gen) during which req_ready is low. A stalled
// result holds its register; the input stage takes one more request, then req_ready
// stays low until the result is taken.
module keyed_bit_permute_xor_cipher_core import kbpx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [31:0]         req_position,
   input  logic [WordBits-1:0] req_data_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WordBits-1:0] rsp_result_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [AddrBits-1:0] paddr,
   input  logic [CsrBits-1:0]  pwdata,
   output logic [CsrBits-1:0]  prdata,
   output logic                pready
);

   build_req_type build_req;
   order_tab_type order_tab;
   order_tab_type inv_tab;
   logic          build_busy;

   kbpx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .build_req (build_req)
   );

   kbpx_order_gen u_order_gen (
      .clock     (clock),
      .reset     (reset),
      .build_req (build_req),
      .order_tab (order_tab),
      .inv_tab   (inv_tab),
      .busy      (build_busy)
   );

   kbpx_word_pipe u_word_pipe (
      .clock           (clock),
      .reset           (reset),
      .hold            (build_busy),
      .order_tab       (order_tab),
      .inv_tab         (inv_tab),
      .key_high        (build_req.key.high),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_data_word   (req_data_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_word (rsp_result_word)
   );

   // no request taken while the permutation is rebuilt
   a_no_req_while_building: assert property (
      @(posedge clock) disable iff (reset) build_busy |-> !req_ready
   ) else $error("request accepted during permutation rebuild");

   // a key write starts a rebuild
   a_key_write_rebuilds: assert property (
      @(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[4:3] == RegKeyLow || paddr[4:3] == RegKeyMid
         || paddr[4:3] == RegKeyHigh)) |=> build_busy
   ) else $error("key write did not start a rebuild");

   // reset leaves no result pending and no rebuild running
   a_reset_clears: assert property (
      @(posedge clock) reset |=> (!rsp_valid && !build_busy)
   ) else $error("state left over after reset");

endmodule
